>>> rtl/smac_pkg.sv
// Shared types and constants of the shadow memory access checker.
// Holds the request/response beat structs and the controller/datapath command
// and status bundles. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smac_pkg;

	// Geometry of the shadow store and the address space
	localparam int SHADOW_ENTRIES = 4096;
	localparam int ADDR_BITS      = 48;
	localparam int GRANULE_SHIFT  = 3;
	localparam int GRANULE_MASK   = 7;
	localparam int IDX_BITS       = $clog2(SHADOW_ENTRIES);
	localparam int OFF_BITS       = IDX_BITS + GRANULE_SHIFT;
	localparam longint WINDOW_BYTES = longint'(SHADOW_ENTRIES) << GRANULE_SHIFT;

	// Field widths
	localparam int LEN_BITS      = 16;
	localparam int CODE_BITS     = 8;
	localparam int STATUS_BITS   = 2;
	localparam int CFG_DATA_BITS = 48;
	localparam int CNT_BITS      = LEN_BITS - GRANULE_SHIFT;

	// Width of the window-relative end offset of an access
	localparam int END_BITS = ((OFF_BITS > LEN_BITS) ? OFF_BITS : LEN_BITS) + 1;
	// Width of a granule index plus a granule count
	localparam int SUM_BITS = (((IDX_BITS + 1) > CNT_BITS) ? (IDX_BITS + 1) : CNT_BITS) + 1;

	// Configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_ENABLE = 1'b0;
	localparam cfg_index_t CFG_BASE   = 1'b1;

	// Response status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FAULT     = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_MALFORMED = 2'd2;

	// Request beat
	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] addr;
		logic [LEN_BITS-1:0]  length;
		logic [LEN_BITS-1:0]  total_length;
		logic [CODE_BITS-1:0] mark_code;
		logic                 is_read;
	} smac_req_t;

	// Response beat
	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [CODE_BITS-1:0]   fault_code;
		logic                   access_was_read;
	} smac_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic                   load;
		logic                   setup;
		logic                   rd_next;
		logic                   mark_wr;
		logic                   clear_wr;
		logic                   res_load;
		logic [STATUS_BITS-1:0] res_code;
	} smac_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_mark;
		logic skip;
		logic malformed;
		logic mark_empty;
		logic bad;
		logic at_last;
		logic mark_last;
		logic clear_last;
	} smac_stat_t;

endpackage

`default_nettype wire

>>> rtl/smac_datapath.sv
// Datapath of the shadow memory access checker: configuration registers,
// item register, window offset logic, shadow store and response register.
// Depends on smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smac_pkg::smac_cmd_t                 cmd,
	output smac_pkg::smac_stat_t                stat,
	input  smac_pkg::smac_req_t                 req,
	input  logic                                cfg_we,
	input  smac_pkg::cfg_index_t                cfg_index,
	input  logic [smac_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output smac_pkg::smac_rsp_t                 rsp
);
	import smac_pkg::*;

	localparam logic [ADDR_BITS:0] WIN_A = (ADDR_BITS + 1)'(WINDOW_BYTES);

	logic                 enable_q;
	logic [ADDR_BITS-1:0] base_q;
	smac_req_t            item_q;
	logic [ADDR_BITS-1:0] off0_q;
	logic [IDX_BITS-1:0]  gcur_q;
	logic [IDX_BITS-1:0]  glast_q;
	logic [2:0]           hi_last_q;
	logic [IDX_BITS:0]    gend_q;
	logic [IDX_BITS:0]    gfull_q;
	logic [CODE_BITS-1:0] mem [SHADOW_ENTRIES];
	logic [CODE_BITS-1:0] rd_q;
	smac_rsp_t            rsp_q;

	logic                 in_win;
	logic                 over_win;
	logic [IDX_BITS:0]    start_ext;
	logic [CNT_BITS-1:0]  count;
	logic [CNT_BITS-1:0]  full;
	logic [SUM_BITS-1:0]  span;
	logic [SUM_BITS-1:0]  full_abs;
	logic [END_BITS-1:0]  end_m1;
	logic                 beyond;
	logic                 malformed;
	logic [IDX_BITS-1:0]  rd_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [CODE_BITS-1:0] wr_data;
	logic [CODE_BITS-1:0] mark_val;
	logic [2:0]           hi;
	logic                 bad;
	logic                 is_fault;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			base_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_BASE:   base_q   <= ADDR_BITS'(cfg_data) & ~ADDR_BITS'(GRANULE_MASK);
				default: ;
			endcase
		end
	end

	// Capture the item and its offset from the window start
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
			off0_q <= req.addr - base_q;
		end
	end

	// Window and range checks on the captured item
	always_comb begin
		in_win    = {1'b0, off0_q} < WIN_A;
		over_win  = {1'b0, off0_q} > WIN_A;
		start_ext = off0_q[OFF_BITS:GRANULE_SHIFT];
		count     = item_q.total_length[LEN_BITS-1:GRANULE_SHIFT];
		full      = item_q.length[LEN_BITS-1:GRANULE_SHIFT];
		span      = SUM_BITS'(start_ext) + SUM_BITS'(count);
		full_abs  = SUM_BITS'(start_ext) + SUM_BITS'(full);
		end_m1    = END_BITS'(off0_q[OFF_BITS-1:0]) + END_BITS'(item_q.length)
			- END_BITS'(1);
		beyond    = end_m1 >= END_BITS'(WINDOW_BYTES);
		malformed = (item_q.addr[GRANULE_SHIFT-1:0] != '0)
			|| (item_q.total_length[GRANULE_SHIFT-1:0] != '0)
			|| (item_q.length > item_q.total_length)
			|| over_win
			|| (span > SUM_BITS'(SHADOW_ENTRIES));
	end

	// Hold the walk limits for the granule loop
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			glast_q   <= beyond ? IDX_BITS'(SHADOW_ENTRIES - 1)
				: end_m1[OFF_BITS-1:GRANULE_SHIFT];
			hi_last_q <= beyond ? 3'd7 : end_m1[2:0];
			gend_q    <= span[IDX_BITS:0];
			gfull_q   <= full_abs[IDX_BITS:0];
		end
	end

	// Granule pointer: load at setup, advance on every clearing, mark or read-ahead step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcur_q <= '0;
		end else if (cmd.setup) begin
			gcur_q <= off0_q[OFF_BITS-1:GRANULE_SHIFT];
		end else if (cmd.clear_wr || cmd.mark_wr || cmd.rd_next) begin
			gcur_q <= gcur_q + IDX_BITS'(1);
		end
	end

	// Shadow byte written by a mark at the current granule
	always_comb begin
		if ({1'b0, gcur_q} < gfull_q) begin
			mark_val = '0;
		end else if (({1'b0, gcur_q} == gfull_q) && (item_q.length[2:0] != 3'd0)) begin
			mark_val = CODE_BITS'(item_q.length[2:0]);
		end else begin
			mark_val = item_q.mark_code;
		end
	end

	assign rd_addr = cmd.rd_next ? (gcur_q + IDX_BITS'(1)) : off0_q[OFF_BITS-1:GRANULE_SHIFT];
	assign rd_en   = cmd.setup || cmd.rd_next;
	assign wr_en   = cmd.clear_wr || cmd.mark_wr;
	assign wr_data = cmd.clear_wr ? '0 : mark_val;

	// Shadow store, one port used per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[gcur_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Judge the granule just read: fault if bit 7 of the shadow value is set or a covered offset reaches it
	always_comb begin
		hi  = (gcur_q == glast_q) ? hi_last_q : 3'd7;
		bad = rd_q[7] || ((rd_q != '0) && (rd_q[6:3] == 4'd0) && (hi >= rd_q[2:0]));
	end

	always_comb begin
		stat.is_mark    = item_q.func;
		stat.skip       = !enable_q || !in_win || (item_q.length == '0);
		stat.malformed  = malformed;
		stat.mark_empty = (count == '0);
		stat.bad        = bad;
		stat.at_last    = (gcur_q == glast_q);
		stat.mark_last  = (({1'b0, gcur_q} + (IDX_BITS + 1)'(1)) == gend_q);
		stat.clear_last = (gcur_q == IDX_BITS'(SHADOW_ENTRIES - 1));
	end

	// Response register
	assign is_fault = (cmd.res_code == STATUS_FAULT);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.status          <= cmd.res_code;
			rsp_q.fault_code      <= is_fault ? rd_q : '0;
			rsp_q.access_was_read <= is_fault ? item_q.is_read : 1'b0;
		end
	end

	assign rsp = rsp_q;

	// A mark never writes past the end of its range
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> ({1'b0, gcur_q} < gend_q))
		else $error("mark write beyond range end");

	// The read ahead only runs while granules remain
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> (gcur_q != glast_q))
		else $error("read ahead past last granule");

	// A fault always reports a non-zero shadow byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && is_fault) |-> (rd_q != '0))
		else $error("fault with zero shadow byte");

endmodule

`default_nettype wire

>>> rtl/smac_ctrl.sv
// Controller of the shadow memory access checker: sequences the clearing pass,
// item setup, granule walk and response hand-off.
// Depends on smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  smac_pkg::smac_stat_t  stat,
	output smac_pkg::smac_cmd_t   cmd
);
	import smac_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_MARK  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t                 state_q;
	state_t                 state_d;
	logic [STATUS_BITS-1:0] res_code_q;
	logic [STATUS_BITS-1:0] res_code_d;
	logic                   rsp_valid_q;
	logic                   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		res_code_d   = res_code_q;
		cmd          = '0;
		cmd.res_code = res_code_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (stat.is_mark) begin
					if (stat.malformed) begin
						res_code_d = STATUS_MALFORMED;
						state_d    = ST_RESP;
					end else if (stat.mark_empty) begin
						res_code_d = STATUS_OK;
						state_d    = ST_RESP;
					end else begin
						state_d = ST_MARK;
					end
				end else if (stat.skip) begin
					res_code_d = STATUS_OK;
					state_d    = ST_RESP;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.bad) begin
					res_code_d = STATUS_FAULT;
					state_d    = ST_RESP;
				end else if (stat.at_last) begin
					res_code_d = STATUS_OK;
					state_d    = ST_RESP;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_MARK: begin
				cmd.mark_wr = 1'b1;
				if (stat.mark_last) begin
					res_code_d = STATUS_OK;
					state_d    = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, result code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_code_q  <= STATUS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_code_q <= res_code_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// An accepted beat always moves on to setup
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_SETUP))
		else $error("accepted beat did not reach setup");

	// Never overwrite a response beat that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(rsp_valid_q && rsp_stall))
		else $error("response overwritten while stalled");

	// The clearing pass takes no beats and shows no response
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (req_stall && !rsp_valid_q))
		else $error("traffic during clearing pass");

endmodule

`default_nettype wire

>>> rtl/shadow_memory_access_checker.sv
// Shadow memory access checker, top level.
// Joins the controller and the datapath. Depends on smac_pkg, smac_ctrl and
// smac_datapath.
//
// Keeps one shadow byte per 8-byte granule of a window of SHADOW_ENTRIES
// granules starting at window_base; mark beats set a range of shadow bytes and
// check beats test every byte of an access against them, one response beat per
// request. After reset a clearing pass zeroes the shadow store, one entry a
// cycle, while no request is taken; configuration writes are taken at any
// time. The shadow store has a single port and does one read or one write
// per cycle: a check walks the granules inside the window that the access
// touches, reading one per step, and stops early at the first fault; a check
// that is disabled, empty or outside the window skips the walk. A valid mark
// writes its granules one per step, and a malformed or empty mark writes
// none. A new request is taken while the previous response still waits in
// the output register.
`timescale 1ns / 1ps
`default_nettype none

module shadow_memory_access_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  smac_pkg::smac_req_t                 req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output smac_pkg::smac_rsp_t                 rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  smac_pkg::cfg_index_t                cfg_index,
	input  logic [smac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import smac_pkg::*;

	smac_cmd_t  cmd;
	smac_stat_t stat;

	// Registers are always free to take a write
	assign cfg_ready = 1'b1;

	smac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	smac_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> sim/shadow_memory_access_checker_tb.sv
// Self-checking testbench for the shadow memory access checker.
// Holds a scoreboard class that mirrors the shadow store, plus tasks that drive
// request, response and register channels. Depends on smac_pkg and the RTL top.
`timescale 1ns / 1ps

// Mirror of the shadow store; predicts one response beat per request beat
class shadow_scoreboard;
	logic [7:0]            shadow [smac_pkg::SHADOW_ENTRIES];
	logic                  enable;
	logic [47:0]           base;
	smac_pkg::smac_rsp_t   rsp_q [$];
	int                    errors;
	int                    n_check;
	int                    n_mark;
	int                    n_fault;
	int                    n_malformed;

	function new();
		foreach (shadow[i]) shadow[i] = 8'h00;
		enable      = 1'b0;
		base        = '0;
		errors      = 0;
		n_check     = 0;
		n_mark      = 0;
		n_fault     = 0;
		n_malformed = 0;
	endfunction

	function void write_reg(smac_pkg::cfg_index_t idx, logic [47:0] data);
		case (idx)
			smac_pkg::CFG_ENABLE: begin
				enable = data[0];
			end
			smac_pkg::CFG_BASE: begin
				base = data;
			end
			default: begin
			end
		endcase
	endfunction

	// Offset from the granule-aligned window start, wrapping at 2^48
	function logic [47:0] win_off(logic [47:0] a);
		logic [47:0] b;
		b = {base[47:3], 3'b000};
		return a - b;
	endfunction

	function int pending();
		return rsp_q.size();
	endfunction

	// Work out the response for an accepted request and apply any mark
	function void note_req(smac_pkg::smac_req_t r);
		smac_pkg::smac_rsp_t exp_rsp;
		logic [47:0]         off;
		logic [7:0]          s;
		longint              start;
		longint              count;
		longint              full;
		longint              part;
		exp_rsp = '0;
		off     = win_off(r.addr);
		if (r.func) begin
			n_mark++;
			start = longint'(off >> 3);
			count = longint'(r.total_length >> 3);
			if (r.addr[2:0] != 3'd0 || r.total_length[2:0] != 3'd0 ||
			    r.length > r.total_length || longint'(off) > smac_pkg::WINDOW_BYTES ||
			    start + count > longint'(smac_pkg::SHADOW_ENTRIES)) begin
				exp_rsp.status = smac_pkg::STATUS_MALFORMED;
				n_malformed++;
			end else begin
				full = longint'(r.length >> 3);
				part = longint'(r.length[2:0]);
				for (longint k = 0; k < count; k++) begin
					if (k < full)
						shadow[smac_pkg::IDX_BITS'(start + k)] = 8'h00;
					else if (k == full && part != 0)
						shadow[smac_pkg::IDX_BITS'(start + k)] = 8'(part);
					else
						shadow[smac_pkg::IDX_BITS'(start + k)] = r.mark_code;
				end
			end
		end else begin
			n_check++;
			if (enable && longint'(off) < smac_pkg::WINDOW_BYTES) begin
				for (int i = 0; i < int'(r.length); i++) begin
					off = win_off(r.addr + 48'(i));
					if (longint'(off) < smac_pkg::WINDOW_BYTES) begin
						s = shadow[off[smac_pkg::OFF_BITS-1:3]];
						if (s != 8'h00 && (s[7] || {5'd0, off[2:0]} >= s)) begin
							exp_rsp.status          = smac_pkg::STATUS_FAULT;
							exp_rsp.fault_code      = s;
							exp_rsp.access_was_read = r.is_read;
							n_fault++;
							break;
						end
					end
				end
			end
		end
		rsp_q.push_back(exp_rsp);
	endfunction

	// Compare a delivered response beat with the oldest prediction
	function void check_rsp(smac_pkg::smac_rsp_t got);
		smac_pkg::smac_rsp_t exp_rsp;
		if (rsp_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: response beat with nothing outstanding: status %0d code %02h rd %0b",
				         $realtime, got.status, got.fault_code, got.access_was_read);
			return;
		end
		exp_rsp = rsp_q.pop_front();
		if (got.status != exp_rsp.status || got.fault_code != exp_rsp.fault_code ||
		    got.access_was_read != exp_rsp.access_was_read) begin
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch: status %0d/%0d code %02h/%02h rd %0b/%0b (exp/got)",
				         $realtime, exp_rsp.status, got.status, exp_rsp.fault_code,
				         got.fault_code, exp_rsp.access_was_read, got.access_was_read);
		end
	endfunction
endclass

module shadow_memory_access_checker_tb;
	import smac_pkg::*;

	localparam int     PHASE_ITEMS = 200;
	localparam int     IDLE_LIMIT  = 40000;
	localparam longint WB          = WINDOW_BYTES;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	smac_req_t                req       = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	smac_rsp_t                rsp;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	cfg_index_t               cfg_index = CFG_ENABLE;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	shadow_scoreboard sb = new();
	logic [47:0]      cur_base;
	int               n_cfg = 0;

	shadow_memory_access_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	// Check beat; the mark-only fields carry noise
	function automatic smac_req_t mk_check(logic [47:0] a, int len, logic rd);
		smac_req_t r;
		r.func         = 1'b0;
		r.addr         = a;
		r.length       = 16'(len);
		r.total_length = 16'($urandom);
		r.mark_code    = 8'($urandom);
		r.is_read      = rd;
		return r;
	endfunction

	function automatic smac_req_t mk_mark(logic [47:0] a, int valid, int total, logic [7:0] code);
		smac_req_t r;
		r.func         = 1'b1;
		r.addr         = a;
		r.length       = 16'(valid);
		r.total_length = 16'(total);
		r.mark_code    = code;
		r.is_read      = 1'($urandom);
		return r;
	endfunction

	// Random request: mostly well-formed marks and checks around busy granules
	function automatic smac_req_t gen_item();
		smac_req_t   r;
		logic [47:0] b;
		int          g;
		int          n;
		int          sel;
		int          len;
		b = {cur_base[47:3], 3'b000};
		case ($urandom_range(0, 3))
			0: g = $urandom_range(0, 31);
			1: g = $urandom_range(SHADOW_ENTRIES - 32, SHADOW_ENTRIES - 1);
			2: g = $urandom_range(1000, 1063);
			default: g = $urandom_range(0, SHADOW_ENTRIES - 1);
		endcase
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			n = $urandom_range(0, 19);
			if (n < 14)
				n = $urandom_range(1, 8);
			else if (n < 19)
				n = $urandom_range(1, 64);
			else
				n = $urandom_range(1, 512);
			if (n > SHADOW_ENTRIES - g)
				n = SHADOW_ENTRIES - g;
			r = mk_mark(b + 48'(g * 8), $urandom_range(0, n * 8), n * 8,
			            ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF0, 8'hFF))
			                                        : 8'($urandom));
		end else if (sel < 80) begin
			n = $urandom_range(0, 99);
			if (n < 60) begin
				len = 1 << $urandom_range(0, 4);
			end else if (n < 98) begin
				len = $urandom_range(0, 64);
			end else begin
				len = $urandom_range(0, 32768);
			end
			r = mk_check(b + 48'(g * 8 + $urandom_range(0, 7)), len, 1'($urandom));
		end else if (sel < 90) begin
			if ($urandom_range(0, 1) != 0)
				r = mk_check(b + 48'(WB) - 48'($urandom_range(1, 40)),
				             $urandom_range(1, 80), 1'($urandom));
			else
				r = mk_check(b - 48'($urandom_range(1, 40)), $urandom_range(1, 80),
				             1'($urandom));
		end else begin
			r.func         = 1'($urandom);
			r.addr         = ($urandom_range(0, 1) != 0) ? rand48() : b + 48'($urandom_range(0, 40000));
			r.length       = 16'($urandom_range(0, 32768));
			r.total_length = 16'($urandom_range(0, 32768));
			r.mark_code    = 8'($urandom);
			r.is_read      = 1'($urandom);
			if (r.func && $urandom_range(0, 1) != 0) begin
				r.length       = 16'($urandom_range(0, 64));
				r.total_length = 16'($urandom_range(0, 64));
			end
		end
		return r;
	endfunction

	// Offer a request beat and hold it until it is taken
	task automatic send_req(smac_req_t r);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.note_req(r);
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_index_t idx, logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		n_cfg++;
	endtask

	// Write both registers, then drop the register channel
	task automatic set_config(logic en, logic [47:0] b);
		cfg_write(CFG_ENABLE, {47'd0, en});
		cfg_write(CFG_BASE, b);
		cfg_valid <= 1'b0;
		cur_base = b;
	endtask

	// Response side: score accepted beats, stall on a shifting pattern
	int stall_mode = 0;
	int mode_left  = 200;
	int run_left   = 0;
	logic stall_nxt;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(64, 256);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			1: stall_nxt = ($urandom_range(0, 3) == 0);
			2: begin
				if (run_left == 0) begin
					stall_nxt = ~rsp_stall;
					run_left  = stall_nxt ? $urandom_range(1, 15) : $urandom_range(1, 10);
				end else begin
					stall_nxt = rsp_stall;
					run_left--;
				end
			end
			3: stall_nxt = ~rsp_stall;
			default: stall_nxt = 1'b0;
		endcase
		rsp_stall <= stall_nxt;
	end

	// Watchdog: end the run if no channel moves a beat for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
		$display("shadow_memory_access_checker_tb: done, errors");
		$finish;
	end

	// Stimulus
	initial begin
		logic [47:0] b;
		logic        en;
		logic        no_gaps;
		int          burst_left;
		int          gap;
		logic        drain;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: marks land while disabled, checks pass regardless
		b = 48'h0000_7654_3200;
		set_config(1'b0, b);
		send_req(mk_mark(b, 0, 64, 8'hFA));
		send_req(mk_check(b, 8, 1'b1));
		req_valid <= 1'b0;
		wait_drain();
		set_config(1'b1, b);

		// Directed: faults, partial granules, window edges, malformed marks
		send_req(mk_check(b, 8, 1'b1));
		send_req(mk_mark(b, 13, 32, 8'hFB));
		send_req(mk_check(b + 48'd8, 5, 1'b0));
		send_req(mk_check(b + 48'd8, 6, 1'b0));
		send_req(mk_check(b, 0, 1'b1));
		send_req(mk_check(b - 48'd4, 16, 1'b1));
		send_req(mk_mark(b + 48'd64, 0, 8, 8'h40));
		send_req(mk_check(b + 48'd64, 8, 1'b1));
		send_req(mk_mark(b + 48'd128, 15, 16, 8'hFC));
		send_req(mk_check(b + 48'd128, 16, 1'b0));
		send_req(mk_mark(b + 48'(WB) - 48'd16, 0, 16, 8'h80));
		send_req(mk_check(b + 48'(WB) - 48'd8, 16, 1'b1));
		send_req(mk_mark(b + 48'(WB) - 48'd8, 8, 8, 8'h00));
		send_req(mk_check(b + 48'(WB) - 48'd4, 100, 1'b0));
		send_req(mk_mark(b + 48'd4, 0, 8, 8'hFF));
		send_req(mk_mark(b, 0, 12, 8'hFF));
		send_req(mk_mark(b, 24, 16, 8'hFF));
		send_req(mk_mark(b + 48'(WB) - 48'd8, 0, 16, 8'hFF));
		send_req(mk_mark(b - 48'd8, 0, 8, 8'hFF));
		send_req(mk_mark(b + 48'(WB), 0, 0, 8'hFF));
		send_req(mk_check(48'hFFFF_FFFF_FFFF, 32768, 1'b1));
		send_req(mk_mark(b, 32768, 32768, 8'hFF));
		send_req(mk_check(b, 32768, 1'b0));
		req_valid <= 1'b0;
		wait_drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			no_gaps = 1'b0;
			case (ph)
				0: begin en = 1'b1; b = 48'd0; no_gaps = 1'b1; end
				1: begin en = 1'b1; b = 48'hFFFF_FFFF_FFFF - 48'd7999; end
				2: begin en = 1'b0; b = rand48() & ~48'h7; end
				3: begin en = 1'b1; b = rand48() | 48'd5; end
				4: begin en = 1'b1; b = 48'hFFFF_FFFF_FFFF; end
				default: begin en = 1'b1; b = rand48(); end
			endcase
			set_config(en, b);
			burst_left = $urandom_range(1, 20);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_req(gen_item());
				drain = ($urandom_range(0, 149) == 0);
				gap   = 0;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					if (!no_gaps && $urandom_range(0, 3) != 0)
						gap = $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
				// Pause the sender: a gap, or a hold until every response is back
				if (gap != 0 || drain) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
					if (drain)
						wait_drain();
				end
			end
			req_valid <= 1'b0;
			wait_drain();
		end

		wait_drain();
		repeat (20) @(posedge clk);
		$display("run: %0d checks, %0d marks, %0d faults, %0d malformed marks predicted",
		         sb.n_check, sb.n_mark, sb.n_fault, sb.n_malformed);
		$display("run: %0d register writes over 8 settings, %0d failures, %0d responses outstanding",
		         n_cfg, sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("shadow_memory_access_checker_tb: done, clean");
		else
			$display("shadow_memory_access_checker_tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/smac_pkg.sv
rtl/smac_datapath.sv
rtl/smac_ctrl.sv
rtl/shadow_memory_access_checker.sv
sim/shadow_memory_access_checker_tb.sv
